FILE: hw/rtl/dgpio_pkg.sv
// Shared types and constants for the dual GPIO port with pin interrupts.
// Used by dgpio_core and dual_gpio_port_with_pin_irq; no dependencies.
`default_nettype none

package dgpio_pkg;

  localparam int PORT_COUNT = 2;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_READ      = 2'd1,
    CMD_PIN_EVENT = 2'd2,
    CMD_IRQ_ACK   = 2'd3
  } cmd_t;

  // register offsets within a port
  localparam logic [1:0] REG_DIR   = 2'd0;
  localparam logic [1:0] REG_LATCH = 2'd1;
  localparam logic [1:0] REG_PIN   = 2'd2;
  localparam logic [1:0] REG_IEN   = 2'd3;

  // bus address windows
  localparam logic [7:0] PORT_A_LAST = 8'd3;
  localparam logic [7:0] PORT_B_BASE = 8'd10;
  localparam logic [7:0] PORT_B_LAST = 8'd13;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] address;
    logic [7:0] write_data;
    logic [3:0] pin_line;
    logic       pin_level;
  } item_t;

  typedef struct packed {
    logic [15:0] irq_pending;
    logic [7:0]  read_data;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dgpio_core.sv
// Port register file, address decode and interrupt flag logic.
// Depends on dgpio_pkg.
`default_nettype none

module dgpio_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  dgpio_pkg::item_t   item,
  output dgpio_pkg::result_t result
);
  import dgpio_pkg::*;

  logic [7:0]  direction    [PORT_COUNT];
  logic [7:0]  output_latch [PORT_COUNT];
  logic [7:0]  pin_levels   [PORT_COUNT];
  logic [7:0]  irq_enable   [PORT_COUNT];
  logic [15:0] irq_flags;

  logic        port_sel;
  logic        mapped;
  logic [1:0]  reg_sel;
  logic [7:0]  cur_dir, cur_latch, cur_pins, cur_ien;
  logic [7:0]  dir_next, latch_next, pins_next, ien_next;
  logic [15:0] irq_flags_next;
  logic [7:0]  read_data;
  logic [7:0]  pin_mask;
  logic [15:0] line_mask;

  // event and ack pick the port from the pin line, bus accesses from the address
  always_comb begin
    mapped   = 1'b0;
    port_sel = 1'b0;
    reg_sel  = item.address[1:0];
    if (item.cmd == CMD_PIN_EVENT || item.cmd == CMD_IRQ_ACK) begin
      port_sel = item.pin_line[3];
    end else if (item.address <= PORT_A_LAST) begin
      mapped = 1'b1;
    end else if (item.address >= PORT_B_BASE && item.address <= PORT_B_LAST) begin
      mapped   = 1'b1;
      port_sel = 1'b1;
      reg_sel  = 2'(item.address - PORT_B_BASE);
    end
  end

  always_comb begin
    cur_dir        = direction[port_sel];
    cur_latch      = output_latch[port_sel];
    cur_pins       = pin_levels[port_sel];
    cur_ien        = irq_enable[port_sel];
    pin_mask       = 8'd1 << item.pin_line[2:0];
    line_mask      = 16'd1 << item.pin_line;
    dir_next       = cur_dir;
    latch_next     = cur_latch;
    pins_next      = cur_pins;
    ien_next       = cur_ien;
    irq_flags_next = irq_flags;
    read_data      = 8'd0;
    case (item.cmd)
      CMD_WRITE: begin
        if (mapped) begin
          case (reg_sel)
            REG_DIR: dir_next = item.write_data;
            REG_LATCH: begin
              latch_next = item.write_data;
              pins_next  = (cur_pins & ~cur_dir) | (item.write_data & cur_dir);
            end
            REG_IEN: ien_next = item.write_data & ~cur_dir;
            default: ; // pin register is read-only
          endcase
        end
      end
      CMD_READ: begin
        if (mapped) begin
          case (reg_sel)
            REG_DIR:   read_data = cur_dir;
            REG_LATCH: read_data = cur_latch;
            REG_PIN:   read_data = (cur_pins & ~cur_dir) | (cur_latch & cur_dir);
            REG_IEN:   read_data = cur_ien;
            default:   read_data = 8'd0;
          endcase
        end
      end
      CMD_PIN_EVENT: begin
        if (((cur_pins & pin_mask) != 8'd0) != item.pin_level &&
            (cur_ien & pin_mask) != 8'd0) begin
          irq_flags_next = irq_flags | line_mask;
        end
        pins_next = item.pin_level ? (cur_pins | pin_mask) : (cur_pins & ~pin_mask);
      end
      CMD_IRQ_ACK: irq_flags_next = irq_flags & ~line_mask;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        direction[i]    <= 8'd0;
        output_latch[i] <= 8'd0;
        pin_levels[i]   <= 8'd0;
        irq_enable[i]   <= 8'd0;
      end
      irq_flags <= 16'd0;
    end else if (en) begin
      direction[port_sel]    <= dir_next;
      output_latch[port_sel] <= latch_next;
      pin_levels[port_sel]   <= pins_next;
      irq_enable[port_sel]   <= ien_next;
      irq_flags              <= irq_flags_next;
    end
  end

  assign result.read_data   = read_data;
  assign result.irq_pending = irq_flags_next;

endmodule

`default_nettype wire

FILE: hw/rtl/dual_gpio_port_with_pin_irq.sv
// Top level of the dual GPIO port: input stage, output register, core instance.
// Depends on dgpio_pkg and dgpio_core.
`default_nettype none

// Two 8-bit GPIO ports (A at bus addresses 0-3, B at 10-13: direction, latch,
// pins, irq enable) with 16 latched pin-change interrupt flags. Each transaction
// on the input stream is a bus write, bus read, pin change event or irq
// acknowledge, and yields exactly one result transaction carrying the read data
// (zero unless a read) and the flags after that transaction. The block takes one
// transaction per cycle. The accepting edge loads the input register. The
// register/flag update is applied and the result register loaded as the
// transaction advances out of the input register, which it can do only once
// the result register is empty or its result is being taken. Back pressure on
// the output stalls the input only once both stages are full.
module dual_gpio_port_with_pin_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] address, [15:8] write_data, [19:16] pin_line, [20] pin_level, [23:21] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [23:8] irq_pending
  output logic [23:0] m_axis_tdata
);
  import dgpio_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t res_q;
  result_t core_result;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (!out_valid || m_axis_tready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd        <= cmd_t'(s_axis_tuser);
      in_item.address    <= s_axis_tdata[7:0];
      in_item.write_data <= s_axis_tdata[15:8];
      in_item.pin_line   <= s_axis_tdata[19:16];
      in_item.pin_level  <= s_axis_tdata[20];
    end
    if (advance) begin
      res_q <= core_result;
    end
  end

  dgpio_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .result (core_result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {res_q.irq_pending, res_q.read_data};

`ifndef NO_ASSERTIONS
  // input only stalls when both stages hold a transaction and output is blocked
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // an acknowledge leaves its flag clear in the result
  a_ack_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.cmd == CMD_IRQ_ACK) |=>
      !res_q.irq_pending[$past(in_item.pin_line)])
    else $error("acknowledged irq flag still set");

  // only a bus read returns nonzero data
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.cmd != CMD_READ) |=> (res_q.read_data == 8'd0))
    else $error("read data nonzero on a non-read transaction");
`endif

endmodule

`default_nettype wire
